[rtl/core/lpht_pkg.sv]
package lpht_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [VAL_W-1:0] NO_VALUE = {1'b1, {(VAL_W-1){1'b0}}};

    // One slot as it travels around the ring. The mark flags a slot that
    // takes part in a backward shift after a remove.
    typedef struct packed {
        logic             mark;
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic shift_en;
        logic dir_rev;
    } ring_ctl_t;

endpackage

[rtl/core/lpht_cell.sv]
module lpht_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpht_pkg::ring_ctl_t ctl,
    input  lpht_pkg::slot_t   fwd_in,
    input  lpht_pkg::slot_t   rev_in,
    output lpht_pkg::slot_t   q
);

    lpht_pkg::slot_t slot_reg;
    lpht_pkg::slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift_en)
        begin
            slot_next = ctl.dir_rev ? rev_in : fwd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

[rtl/core/lpht_head.sv]
module lpht_head
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [lpht_pkg::KEY_W-1:0]      lookup_key,
    input  logic [lpht_pkg::VAL_W-1:0]      entry_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [lpht_pkg::VAL_W-1:0]      found_value,
    output lpht_pkg::ring_ctl_t             ctl,
    input  lpht_pkg::slot_t                 head_rd,
    output lpht_pkg::slot_t                 head_wr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [lpht_pkg::IDX_W-1:0] LAST_IDX = lpht_pkg::IDX_W'(lpht_pkg::TABLE_SLOTS - 1);

    logic [1:0]                     state_reg, state_next;
    logic [lpht_pkg::IDX_W-1:0]     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic                           hit_reg, hit_next;
    logic [lpht_pkg::IDX_W-1:0]     hole_reg, hole_next;
    logic [1:0]                     op_reg, op_next;
    logic [lpht_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [lpht_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [1:0]                     res_st_reg, res_st_next;
    logic [lpht_pkg::VAL_W-1:0]     res_val_reg, res_val_next;
    logic                           carry_v_reg, carry_v_next;
    logic [lpht_pkg::KEY_W-1:0]     carry_key_reg, carry_key_next;
    logic [lpht_pkg::VAL_W-1:0]     carry_val_reg, carry_val_next;
    logic                           ov_reg, ov_next;
    logic [1:0]                     ost_reg, ost_next;
    logic [lpht_pkg::VAL_W-1:0]     oval_reg, oval_next;

    logic [lpht_pkg::IDX_W-1:0]     home;
    logic                           in_range;
    logic                           key_match;

    // Home slot is the key modulo a power-of-two table size.
    assign home      = key_reg[lpht_pkg::IDX_W-1:0];
    assign in_range  = (cnt_reg >= home);
    assign key_match = (head_rd.key == key_reg);

    // The ring turns forward while probing and backward while shifting.
    assign ctl.shift_en = (state_reg == S_PROBE) || (state_reg == S_SHIFT);
    assign ctl.dir_rev  = (state_reg == S_SHIFT);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        hit_next       = hit_reg;
        hole_next      = hole_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        res_st_next    = res_st_reg;
        res_val_next   = res_val_reg;
        carry_v_next   = carry_v_reg;
        carry_key_next = carry_key_reg;
        carry_val_next = carry_val_reg;
        ov_next        = ov_reg;
        ost_next       = ost_reg;
        oval_next      = oval_reg;
        head_wr        = head_rd;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    key_next      = lookup_key;
                    val_next      = entry_value;
                    cnt_next      = '0;
                    done_next     = 1'b0;
                    hit_next      = 1'b0;
                    hole_next     = '0;
                    carry_v_next  = 1'b0;
                    res_val_next  = lpht_pkg::NO_VALUE;
                    res_st_next   = (opcode == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                                    : lpht_pkg::ST_MISS;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (in_range && !done_reg)
                begin
                    case (op_reg)
                        lpht_pkg::OP_INSERT:
                        begin
                            if (!head_rd.valid)
                            begin
                                head_wr.valid = 1'b1;
                                head_wr.key   = key_reg;
                                head_wr.value = val_reg;
                                done_next     = 1'b1;
                                res_st_next   = lpht_pkg::ST_OK;
                            end
                            else if (key_match)
                            begin
                                done_next   = 1'b1;
                                res_st_next = lpht_pkg::ST_DUP;
                            end
                        end
                        lpht_pkg::OP_LOOKUP:
                        begin
                            if (!head_rd.valid)
                            begin
                                done_next = 1'b1;
                            end
                            else if (key_match)
                            begin
                                done_next    = 1'b1;
                                res_st_next  = lpht_pkg::ST_OK;
                                res_val_next = head_rd.value;
                            end
                        end
                        lpht_pkg::OP_REMOVE:
                        begin
                            if (!head_rd.valid)
                            begin
                                done_next = 1'b1;
                            end
                            else if (!hit_reg)
                            begin
                                if (key_match)
                                begin
                                    hit_next     = 1'b1;
                                    hole_next    = cnt_reg;
                                    head_wr.mark = 1'b1;
                                    res_st_next  = lpht_pkg::ST_OK;
                                end
                            end
                            else if (head_rd.key[lpht_pkg::IDX_W-1:0] <= hole_reg)
                            begin
                                head_wr.mark = 1'b1;
                                hole_next    = cnt_reg;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = hit_next ? S_SHIFT : S_FIN;
                end
            end
            S_SHIFT:
            begin
                // Walking down from the top, each marked slot takes the entry
                // of the next marked slot above it; the highest one empties.
                if (head_rd.mark)
                begin
                    head_wr.mark   = 1'b0;
                    head_wr.valid  = carry_v_reg;
                    head_wr.key    = carry_v_reg ? carry_key_reg : '0;
                    head_wr.value  = carry_v_reg ? carry_val_reg : '0;
                    carry_v_next   = 1'b1;
                    carry_key_next = head_rd.key;
                    carry_val_next = head_rd.value;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    oval_next  = res_val_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            carry_v_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            carry_v_reg <= carry_v_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg      <= hole_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        res_st_reg    <= res_st_next;
        res_val_reg   <= res_val_next;
        carry_key_reg <= carry_key_next;
        carry_val_reg <= carry_val_next;
        ost_reg       <= ost_next;
        oval_reg      <= oval_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign found_value = oval_reg;

endmodule

[rtl/core/linear_probe_hash_table.sv]
// Channel | Handshake                   | Fields
// in      | in_valid / in_stall         | opcode, lookup_key, entry_value
// out     | out_valid / out_stall       | status, found_value
// The slots sit in a ring of cells that rotates once per pass, one slot a cycle
// past a single head stage. Insert and lookup run one forward probe pass, then
// load the result into the output register; the next beat is taken only once the
// head is idle again, so beats never overlap. A remove that finds its key adds a
// reverse pass for the backward shift before the result load.
// Reset empties every slot at once. A stalled result holds the next one in the
// head until the output register frees; a new beat is taken once the head is idle.
module linear_probe_hash_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [lpht_pkg::KEY_W-1:0]      lookup_key,
    input  logic [lpht_pkg::VAL_W-1:0]      entry_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [lpht_pkg::VAL_W-1:0]      found_value
);

    localparam int N = lpht_pkg::TABLE_SLOTS;

    lpht_pkg::ring_ctl_t ctl;
    lpht_pkg::slot_t     cell_q [N];
    lpht_pkg::slot_t     head_rd;
    lpht_pkg::slot_t     head_wr;

    assign head_rd = ctl.dir_rev ? cell_q[N-1] : cell_q[0];

    lpht_head u_head
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .lookup_key  (lookup_key),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value),
        .ctl         (ctl),
        .head_rd     (head_rd),
        .head_wr     (head_wr)
    );

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        lpht_pkg::slot_t fwd_in;
        lpht_pkg::slot_t rev_in;

        if (k == N - 1)
        begin : g_top
            assign fwd_in = head_wr;
        end
        else
        begin : g_mid_f
            assign fwd_in = cell_q[k+1];
        end

        if (k == 0)
        begin : g_bot
            assign rev_in = head_wr;
        end
        else
        begin : g_mid_r
            assign rev_in = cell_q[k-1];
        end

        lpht_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .fwd_in (fwd_in),
            .rev_in (rev_in),
            .q      (cell_q[k])
        );
    end

endmodule
